[src/deq_pkg.sv]
// ---------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Request codes, field widths and the command/status structs that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package deq_pkg;

    // Default number of entries held by the queue
    localparam int DEPTH_DEF = 64;

    // Field widths
    localparam int REQ_W     = 3;
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 7;
    localparam int M_DATA_W  = 2 * DATA_W + 1 + 2 * CNT_OUT_W + 1;

    // Request codes (6 and 7 act as a query)
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic take;        // latch the input transfer
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic del_init;    // clear the compaction counters
        logic del_step;    // one compaction cycle
        logic cap_front;   // capture read data as front value
        logic cap_back;    // capture read data as back value
        logic out_load;    // load the result register
    } deq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             scan_done;  // every held entry has been read
        logic             rd_pend;    // a compaction read is in flight
        logic             out_free;   // result register can take a new result
        logic             is_full;
        logic             is_empty;
    } deq_stat_t;

endpackage

[src/deq_ram.sv]
// ---------------------------------------------------------------------------
// deq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ---------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/deq_ctrl.sv]
// ---------------------------------------------------------------------------
// deq_ctrl: request sequencer for the double-ended queue
// Accepts one request, steps the datapath through it and hands the result
// to the output register.
// ---------------------------------------------------------------------------
module deq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  deq_pkg::deq_stat_t  stat,
    output deq_pkg::deq_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDF  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_DEL  = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (stat.req)
                    deq_pkg::REQ_PUSH_FRONT: begin
                        cmd.push_front = 1'b1;
                        state_next     = S_RESP;
                    end
                    deq_pkg::REQ_PUSH_BACK: begin
                        cmd.push_back = 1'b1;
                        state_next    = S_RESP;
                    end
                    deq_pkg::REQ_POP_FRONT: begin
                        cmd.pop_front = 1'b1;
                        state_next    = S_RDF;
                    end
                    deq_pkg::REQ_POP_BACK: begin
                        cmd.pop_back = 1'b1;
                        state_next   = S_RDB;
                    end
                    deq_pkg::REQ_DELETE: begin
                        cmd.del_init = 1'b1;
                        state_next   = S_DEL;
                    end
                    default: begin
                        // query and unused codes
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RDF: begin
                cmd.cap_front = 1'b1;
                state_next    = S_RESP;
            end
            S_RDB: begin
                cmd.cap_back = 1'b1;
                state_next   = S_RESP;
            end
            S_DEL: begin
                cmd.del_step = 1'b1;
                if (stat.scan_done && !stat.rd_pend) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/deq_dp.sv]
// ---------------------------------------------------------------------------
// deq_dp: double-ended queue datapath
// Ring buffer pointers, cached end values, entry memory, compaction counters
// and the result register.
// ---------------------------------------------------------------------------
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [deq_pkg::DATA_W-1:0]    s_tdata,
    input  logic [deq_pkg::REQ_W-1:0]     s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [deq_pkg::M_DATA_W-1:0]  m_tdata,
    input  deq_pkg::deq_cmd_t             cmd,
    output deq_pkg::deq_stat_t            stat
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int DW    = deq_pkg::DATA_W;
    localparam int OW    = deq_pkg::CNT_OUT_W;

    // Store index of the entry at offset off from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Count to the 7-bit result field
    function automatic logic [OW-1:0] to_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+OW-1:0] wide;
        wide = {{OW{1'b0}}, c};
        return wide[OW-1:0];
    endfunction

    logic [deq_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [DW-1:0]               val_reg, val_next;
    logic [AW-1:0]               fp_reg, fp_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [DW-1:0]               front_reg, front_next;
    logic [DW-1:0]               back_reg, back_next;
    logic                        ovf_reg, ovf_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]            scan_reg, scan_next;
    logic [CNT_W-1:0]            kept_reg, kept_next;
    logic                        pend_reg, pend_next;
    logic                        mval_reg, mval_next;
    logic [deq_pkg::M_DATA_W-1:0] mdata_reg, mdata_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;
    logic [AW-1:0] fp_dec;
    logic          is_full;
    logic          is_empty;
    logic          scan_done;

    assign is_full   = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty  = (cnt_reg == '0);
    assign scan_done = (scan_reg == cnt_reg);
    assign fp_dec    = (fp_reg == '0) ? AW'(DEPTH - 1) : fp_reg - AW'(1);

    // Status back to the controller
    always_comb begin
        stat.req       = req_reg;
        stat.scan_done = scan_done;
        stat.rd_pend   = pend_reg;
        stat.out_free  = !mval_reg || m_tready;
        stat.is_full   = is_full;
        stat.is_empty  = is_empty;
    end

    // Entry memory
    deq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Request execution
    always_comb begin
        req_next   = req_reg;
        val_next   = val_reg;
        fp_next    = fp_reg;
        cnt_next   = cnt_reg;
        front_next = front_reg;
        back_next  = back_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        scan_next  = scan_reg;
        kept_next  = kept_reg;
        pend_next  = pend_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        we         = 1'b0;
        waddr      = slot_of(fp_reg, cnt_reg);
        wdata      = val_reg;
        raddr      = slot_of(fp_reg, scan_reg);

        if (cmd.take) begin
            req_next = s_tuser;
            val_next = s_tdata;
            ovf_next = 1'b0;
            rem_next = '0;
        end

        // Push at the front: step the front pointer back, then write
        if (cmd.push_front) begin
            if (is_full) begin
                ovf_next = 1'b1;
            end else begin
                we         = 1'b1;
                waddr      = fp_dec;
                fp_next    = fp_dec;
                cnt_next   = cnt_reg + CNT_W'(1);
                front_next = val_reg;
                if (is_empty) begin
                    back_next = val_reg;
                end
            end
        end

        // Push at the back: write just past the last entry
        if (cmd.push_back) begin
            if (is_full) begin
                ovf_next = 1'b1;
            end else begin
                we        = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                back_next = val_reg;
                if (is_empty) begin
                    front_next = val_reg;
                end
            end
        end

        // Pops read the new end entry; it lands in the next cycle
        if (cmd.pop_front) begin
            raddr = slot_of(fp_reg, CNT_W'(1));
            if (!is_empty) begin
                fp_next  = slot_of(fp_reg, CNT_W'(1));
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        if (cmd.pop_back) begin
            raddr = slot_of(fp_reg, cnt_reg - CNT_W'(2));
            if (!is_empty) begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        if (cmd.cap_front) begin
            front_next = rdata;
        end
        if (cmd.cap_back) begin
            back_next = rdata;
        end

        // Delete: read every entry in order, write back the survivors packed
        if (cmd.del_init) begin
            scan_next = '0;
            kept_next = '0;
            pend_next = 1'b0;
        end
        if (cmd.del_step) begin
            if (pend_reg && (rdata != val_reg)) begin
                we        = 1'b1;
                waddr     = slot_of(fp_reg, kept_reg);
                wdata     = rdata;
                kept_next = kept_reg + CNT_W'(1);
                back_next = rdata;
                if (kept_reg == '0) begin
                    front_next = rdata;
                end
            end
            if (!scan_done) begin
                scan_next = scan_reg + CNT_W'(1);
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
            if (scan_done && !pend_reg) begin
                cnt_next = kept_reg;
                rem_next = cnt_reg - kept_reg;
            end
        end

        // Result register
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        if (cmd.out_load) begin
            mval_next = 1'b1;
            mdata_next = {ovf_reg, to_out(rem_reg), to_out(cnt_reg), is_empty,
                          is_empty ? {DW{1'b1}} : back_reg,
                          is_empty ? {DW{1'b1}} : front_reg};
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg   <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            fp_reg   <= fp_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            mval_reg <= mval_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        val_reg   <= val_next;
        front_reg <= front_next;
        back_reg  <= back_next;
        ovf_reg   <= ovf_next;
        rem_reg   <= rem_next;
        scan_reg  <= scan_next;
        kept_reg  <= kept_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

endmodule

[src/double_ended_queue_with_value_delete_top.sv]
// ---------------------------------------------------------------------------
// double_ended_queue_with_value_delete_top: bounded double-ended queue
// Ring-buffer deque of 32-bit values with push/pop at both ends, in-order
// removal of all entries equal to a value, and a status result per request.
// ---------------------------------------------------------------------------
// Each request on the s_ side yields exactly one result on the m_ side. The
// block handles one request at a time. A push or query passes from accept
// through the execute and response states, and a pop also passes a read
// state, since the new end entry comes out of the entry memory's registered
// read port. A delete loops in its own state while the compaction streams
// every held entry through the single read port and writes survivors back
// one per cycle. The result register lets the next request be accepted
// while a result is still waiting to be taken. A push into a full queue is
// refused and flagged by overflow; a pop on an empty queue changes nothing.
module double_ended_queue_with_value_delete_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [31:0] front_value, [63:32] back_value,
                                   // [64] is_empty, [71:65] entry_count,
                                   // [78:72] removed_count, [79] overflow
);

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_stat_t stat;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The queue cannot be full and empty at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.is_full && stat.is_empty))
        else $error("queue reports full and empty together");

    // A refused push only happens with the queue at capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[79]) |-> (m_tdata[71:65] == 7'(DEPTH)))
        else $error("overflow reported below capacity");

    // An empty result shows all ones at both ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64]) |-> (m_tdata[63:0] == {64{1'b1}}))
        else $error("empty result with end values not all ones");

    // Removal and overflow never come from the same request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[78:72] != 7'd0)) |-> !m_tdata[79])
        else $error("removed count and overflow both set");

endmodule

[verif/double_ended_queue_with_value_delete_top_tb.sv]
// ---------------------------------------------------------------------------
// double_ended_queue_with_value_delete_top_tb: self-checking bench for the deque
// Streams push, pop, delete-value and query requests into the block and checks
// every status result against a ring-buffer predictor kept in the bench. Both
// ends idle in random bursts, and one long receiver stall backs up the input.
// ---------------------------------------------------------------------------
module double_ended_queue_with_value_delete_top_tb;

    localparam int DEPTH        = deq_pkg::DEPTH_DEF;
    localparam int REQ_W        = deq_pkg::REQ_W;
    localparam int DATA_W       = deq_pkg::DATA_W;
    localparam int CNT_OUT_W    = deq_pkg::CNT_OUT_W;
    localparam int M_DATA_W     = deq_pkg::M_DATA_W;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CALM_ITEMS   = 150;   // last stretch runs without idling
    localparam int HOLD_AFTER   = 150;   // transfers before the long stall
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT      = 8_000_000;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = deq_pkg::REQ_PUSH_FRONT;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = deq_pkg::REQ_PUSH_BACK;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = deq_pkg::REQ_POP_FRONT;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = deq_pkg::REQ_POP_BACK;
    localparam logic [REQ_W-1:0] REQ_DELETE     = deq_pkg::REQ_DELETE;
    localparam logic [REQ_W-1:0] REQ_QUERY      = deq_pkg::REQ_QUERY;

    // Spare request codes, decoded as a query
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] value;
    } deq_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]    front_value;
        logic [DATA_W-1:0]    back_value;
        logic                 is_empty;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [CNT_OUT_W-1:0] removed_count;
        logic                 overflow;
    } deq_status_t;

    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_PURGE} seg_kind_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic [REQ_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    double_ended_queue_with_value_delete_top #(.DEPTH(DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] value
        .s_tuser  (s_tuser),    // [2:0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [31:0] front, [63:32] back, [64] empty,
                                // [71:65] count, [78:72] removed, [79] overflow
    );

    always #6 aclk = ~aclk;

    // Predicted deque contents
    logic [DATA_W-1:0] dq_store [DEPTH];
    int                dq_head  = 0;
    int                dq_count = 0;

    deq_req_t    pending_reqs [$];
    deq_status_t status_due   [$];
    deq_req_t    cur_req;
    deq_status_t cur_status;
    deq_status_t want_status;
    deq_status_t got_status;

    logic [DATA_W-1:0] value_pool [8];

    int  mismatch_cnt = 0;
    int  result_cnt   = 0;
    int  acc_cnt      = 0;
    int  src_gap      = 0;
    int  sink_gap     = 0;
    logic calm        = 1'b0;
    logic stall_hold  = 1'b0;

    // Apply one request to the predicted deque and build its status
    task automatic deque_apply(input deq_req_t rq, output deq_status_t st);
        int kept;
        int k;
        logic [DATA_W-1:0] v;
        st = '0;
        case (rq.req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (dq_count >= DEPTH) begin
                    st.overflow = 1'b1;
                end else if (rq.req == REQ_PUSH_FRONT) begin
                    dq_head = (dq_head + DEPTH - 1) % DEPTH;
                    dq_store[dq_head] = rq.value;
                    dq_count++;
                end else begin
                    dq_store[(dq_head + dq_count) % DEPTH] = rq.value;
                    dq_count++;
                end
            end
            REQ_POP_FRONT: begin
                if (dq_count > 0) begin
                    dq_head = (dq_head + 1) % DEPTH;
                    dq_count--;
                end
            end
            REQ_POP_BACK: begin
                if (dq_count > 0) dq_count--;
            end
            REQ_DELETE: begin
                // in-order compaction of the survivors toward the front
                kept = 0;
                for (k = 0; k < dq_count; k++) begin
                    v = dq_store[(dq_head + k) % DEPTH];
                    if (v != rq.value) begin
                        dq_store[(dq_head + kept) % DEPTH] = v;
                        kept++;
                    end
                end
                st.removed_count = CNT_OUT_W'(dq_count - kept);
                dq_count = kept;
            end
            default: ;
        endcase
        if (dq_count == 0) begin
            st.front_value = '1;
            st.back_value  = '1;
            st.is_empty    = 1'b1;
        end else begin
            st.front_value = dq_store[dq_head];
            st.back_value  = dq_store[(dq_head + dq_count - 1) % DEPTH];
        end
        st.entry_count = CNT_OUT_W'(dq_count);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_cnt++;
        $display("mismatch at result %0d: %s got %h want %h", result_cnt, what, got, want);
    endtask

    task automatic add_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] value);
        deq_req_t rq;
        rq.req   = req;
        rq.value = value;
        pending_reqs.push_back(rq);
    endtask

    // Half the values, and every purge-segment delete value, come from a small pool so deletes find matches
    function automatic logic [DATA_W-1:0] pick_value(input bit pool_only);
        if (pool_only || $urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [REQ_W-1:0] pick_req(input seg_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            SEG_FILL: begin
                if (r < 45) return REQ_PUSH_FRONT;
                if (r < 88) return REQ_PUSH_BACK;
                if (r < 92) return REQ_POP_FRONT;
                if (r < 95) return REQ_DELETE;
                return REQ_QUERY;
            end
            SEG_DRAIN: begin
                if (r < 40) return REQ_POP_FRONT;
                if (r < 80) return REQ_POP_BACK;
                if (r < 88) return REQ_PUSH_BACK;
                if (r < 94) return REQ_DELETE;
                return REQ_QUERY;
            end
            SEG_PURGE: begin
                if (r < 30) return REQ_PUSH_BACK;
                if (r < 45) return REQ_PUSH_FRONT;
                if (r < 75) return REQ_DELETE;
                if (r < 85) return REQ_POP_FRONT;
                if (r < 90) return REQ_POP_BACK;
                return REQ_QUERY;
            end
            default: begin
                if (r < 20) return REQ_PUSH_FRONT;
                if (r < 40) return REQ_PUSH_BACK;
                if (r < 55) return REQ_POP_FRONT;
                if (r < 70) return REQ_POP_BACK;
                if (r < 85) return REQ_DELETE;
                if (r < 95) return REQ_QUERY;
                if (r < 97) return REQ_SPARE_A;
                return REQ_SPARE_B;
            end
        endcase
    endfunction

    // Driver: offers pending requests, predicts each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deque_apply(cur_req, cur_status);
                status_due.push_back(cur_status);
                acc_cnt++;
                if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7);
            end
            calm <= (pending_reqs.size() < CALM_ITEMS);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_req.value;
                    s_tuser  <= cur_req.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results and compares them with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                got_status.front_value   = m_tdata[31:0];
                got_status.back_value    = m_tdata[63:32];
                got_status.is_empty      = m_tdata[64];
                got_status.entry_count   = m_tdata[71:65];
                got_status.removed_count = m_tdata[78:72];
                got_status.overflow      = m_tdata[79];
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want_status = status_due.pop_front();
                    if (got_status.front_value !== want_status.front_value)
                        report_mismatch("front_value", got_status.front_value,
                                        want_status.front_value);
                    if (got_status.back_value !== want_status.back_value)
                        report_mismatch("back_value", got_status.back_value,
                                        want_status.back_value);
                    if (got_status.is_empty !== want_status.is_empty)
                        report_mismatch("is_empty", DATA_W'(got_status.is_empty),
                                        DATA_W'(want_status.is_empty));
                    if (got_status.entry_count !== want_status.entry_count)
                        report_mismatch("entry_count", DATA_W'(got_status.entry_count),
                                        DATA_W'(want_status.entry_count));
                    if (got_status.removed_count !== want_status.removed_count)
                        report_mismatch("removed_count",
                                        DATA_W'(got_status.removed_count),
                                        DATA_W'(want_status.removed_count));
                    if (got_status.overflow !== want_status.overflow)
                        report_mismatch("overflow", DATA_W'(got_status.overflow),
                                        DATA_W'(want_status.overflow));
                end
            end
            // receiver backpressure: long hold, random bursts, or ready
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (stall_hold) begin
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver stall while the sender keeps offering
    initial begin
        while (acc_cnt < HOLD_AFTER) @(posedge aclk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        stall_hold <= 1'b0;
    end

    initial begin
        #(TIMEOUT);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus build, reset and end of run
    initial begin : stimulus
        int k;
        int len;
        seg_kind_t kind;
        logic [REQ_W-1:0] req;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = 32'h5A5A_5A5A;
        value_pool[6] = $urandom;
        value_pool[7] = $urandom;

        // directed: empty queue, extremes, spare codes, deletes
        add_req(REQ_QUERY, 32'h0);
        add_req(REQ_POP_FRONT, 32'h0);
        add_req(REQ_POP_BACK, 32'h0);
        add_req(REQ_DELETE, 32'hFFFF_FFFF);
        add_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
        add_req(REQ_PUSH_FRONT, 32'h8000_0000);
        add_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
        add_req(REQ_PUSH_FRONT, 32'h0000_0000);
        add_req(REQ_QUERY, 32'hFFFF_FFFF);
        add_req(REQ_SPARE_A, 32'h1234_5678);
        add_req(REQ_SPARE_B, 32'h8765_4321);
        add_req(REQ_DELETE, 32'hFFFF_FFFF);
        add_req(REQ_DELETE, 32'h0000_3039);
        add_req(REQ_PUSH_BACK, 32'h8000_0000);
        add_req(REQ_PUSH_BACK, 32'h8000_0000);
        add_req(REQ_DELETE, 32'h8000_0000);
        add_req(REQ_POP_BACK, 32'h0);
        add_req(REQ_POP_FRONT, 32'h0);
        add_req(REQ_POP_FRONT, 32'h0);
        add_req(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        add_req(REQ_POP_BACK, 32'h0);
        add_req(REQ_QUERY, 32'h0);

        // fill to full with every other entry matching, overflow, half delete
        for (k = 0; k < DEPTH; k++)
            add_req(REQ_PUSH_BACK, (k % 2 == 0) ? 32'h5A5A_5A5A : 32'($urandom));
        add_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        add_req(REQ_PUSH_BACK, 32'h8000_0000);
        add_req(REQ_DELETE, 32'h5A5A_5A5A);
        for (k = 0; k < DEPTH / 2; k++)
            add_req(REQ_POP_BACK, 32'h0);

        // full store of one value, then delete all of it
        for (k = 0; k < DEPTH; k++)
            add_req((k % 3 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 32'h0000_0001);
        add_req(REQ_PUSH_BACK, 32'h0000_0002);
        add_req(REQ_DELETE, 32'h0000_0001);

        // random segments with biased request mixes
        while (pending_reqs.size() < RANDOM_ITEMS) begin
            kind = seg_kind_t'($urandom_range(0, 3));
            len  = (kind == SEG_FILL) ? $urandom_range(70, 100) : $urandom_range(30, 80);
            for (k = 0; k < len; k++) begin
                req = pick_req(kind);
                add_req(req, pick_value(kind == SEG_PURGE && req == REQ_DELETE));
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid) @(posedge aclk);
        while (status_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && status_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue_with_value_delete_top.sv
verif/double_ended_queue_with_value_delete_top_tb.sv
